@@ hdl/bff_pkg.sv @@
package bff_pkg;

    localparam int WORD_BITS    = 64;
    localparam int SEL_W        = 6;
    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int CMP_W        = 17;
    localparam int MAX_BITS_DEF = 4096;

    localparam logic [CNT_W-1:0] BIT_COUNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        REQ_GET  = 2'd0,
        REQ_SET  = 2'd1,
        REQ_FLIP = 2'd2,
        REQ_FIND = 2'd3
    } req_t;

    typedef enum logic {
        UOP_SET  = 1'b0,
        UOP_FLIP = 1'b1
    } uop_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SCAN,
        ST_HIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        uop_t             op;
        logic [SEL_W-1:0] sel;
        logic             value;
        logic             invert;
    } uctl_t;

    typedef struct packed {
        logic             bit_val;
        logic             nonzero;
        logic [SEL_W-1:0] lsb;
    } ures_t;

endpackage

@@ hdl/bitmap_find_and_flip_store.sv @@
// Channel  | Handshake            | Beat contents
// ---------+----------------------+------------------------------------------
// config   | cfg_wr_en            | cfg_wr_data: bit_count
// input    | s_valid / s_ready    | s_req_type, s_bit_index, s_value
// result   | m_valid / m_ready    | m_bit_value, m_found, m_found_index, m_status
//
// Get, set and flip read the map word, then do the read-modify-write in ST_MODIFY and
// load the result beat from ST_DONE; an out-of-range index goes straight to ST_DONE. A
// find reads one map word per cycle through the shared word unit, then on a hit flips
// the bit in ST_HIT before ST_DONE; s_ready rises with m_valid.
// After reset a clearing pass writes zero to every map word, with s_ready low. A stalled
// result beat does not block the next input beat; that item then waits at its end.
module bitmap_find_and_flip_store import bff_pkg::*; #(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [IDX_W-1:0] s_bit_index,
    input  logic             s_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_bit_value,
    output logic             m_found,
    output logic [IDX_W-1:0] m_found_index,
    output logic             m_status
);

    localparam int DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] unit_word;
    logic [WORD_BITS-1:0] unit_mod_word;
    uctl_t                unit_ctl;
    ures_t                unit_res;

    bff_ctrl #(
        .MAX_BITS (MAX_BITS),
        .DEPTH    (DEPTH),
        .AW       (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_bit_index   (s_bit_index),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bit_value   (m_bit_value),
        .m_found       (m_found),
        .m_found_index (m_found_index),
        .m_status      (m_status),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .unit_word     (unit_word),
        .unit_ctl      (unit_ctl),
        .unit_mod_word (unit_mod_word),
        .unit_res      (unit_res)
    );

    bff_map_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bff_word_unit u_unit (
        .word     (unit_word),
        .ctl      (unit_ctl),
        .mod_word (unit_mod_word),
        .res      (unit_res)
    );

endmodule

@@ hdl/bff_map_ram.sv @@
module bff_map_ram import bff_pkg::*; #(
    parameter int DEPTH = MAX_BITS_DEF / WORD_BITS,
    parameter int AW    = 6
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bff_word_unit.sv @@
module bff_word_unit import bff_pkg::*; (
    input  logic [WORD_BITS-1:0] word,
    input  uctl_t                ctl,
    output logic [WORD_BITS-1:0] mod_word,
    output ures_t                res
);

    localparam int GROUPS = WORD_BITS / 8;

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] norm;
    logic [GROUPS-1:0]    grp_nz;
    logic [2:0]           grp;
    logic [7:0]           grp_byte;
    logic [2:0]           bit_pos;

    assign mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << ctl.sel;

    always_comb begin
        unique case (ctl.op)
            UOP_SET:  mod_word = (word & ~mask) | ({WORD_BITS{ctl.value}} & mask);
            UOP_FLIP: mod_word = word ^ mask;
            default:  mod_word = word;
        endcase
    end

    // Lowest matching bit: first the lowest nonzero byte, then the bit within it.
    assign norm = ctl.invert ? ~word : word;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_nz[g] = |norm[g*8 +: 8];
        end
        grp = 3'd0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_nz[g]) begin
                grp = 3'(g);
            end
        end
        grp_byte = norm[{grp, 3'b000} +: 8];
        bit_pos = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (grp_byte[b]) begin
                bit_pos = 3'(b);
            end
        end
    end

    assign res.bit_val = word[ctl.sel];
    assign res.nonzero = |grp_nz;
    assign res.lsb     = {grp, bit_pos};

endmodule

@@ hdl/bff_ctrl.sv @@
module bff_ctrl import bff_pkg::*; #(
    parameter int MAX_BITS = MAX_BITS_DEF,
    parameter int DEPTH    = MAX_BITS_DEF / WORD_BITS,
    parameter int AW       = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [IDX_W-1:0]     s_bit_index,
    input  logic                 s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_bit_value,
    output logic                 m_found,
    output logic [IDX_W-1:0]     m_found_index,
    output logic                 m_status,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [WORD_BITS-1:0] mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  logic [WORD_BITS-1:0] mem_rdata,
    output logic [WORD_BITS-1:0] unit_word,
    output uctl_t                unit_ctl,
    input  logic [WORD_BITS-1:0] unit_mod_word,
    input  ures_t                unit_res
);

    state_t               state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]        last_reg, last_next;
    req_t                 req_reg, req_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 val_reg, val_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] hit_word_reg, hit_word_next;
    logic [SEL_W-1:0]     lsb_reg, lsb_next;
    logic                 res_bit_reg, res_bit_next;
    logic                 res_found_reg, res_found_next;
    logic [IDX_W-1:0]     res_index_reg, res_index_next;
    logic                 res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_bit_reg, m_found_reg, m_status_reg;
    logic [IDX_W-1:0]     m_index_reg;
    logic                 load_out;
    logic [CNT_W-1:0]     bit_count_reg;
    logic [CNT_W-1:0]     cnt_eff;
    req_t                 s_req;
    logic [AW+SEL_W-1:0]  hit_pos;

    assign s_req = req_t'(s_req_type);

    // A count above the map's capacity acts as the capacity.
    assign cnt_eff = (CMP_W'(bit_count_reg) > CMP_W'(MAX_BITS)) ? CNT_W'(MAX_BITS)
                                                               : bit_count_reg;
    assign hit_pos = {addr_reg, lsb_reg};

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        last_next       = last_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        hit_word_next   = hit_word_reg;
        lsb_next        = lsb_reg;
        res_bit_next    = res_bit_reg;
        res_found_next  = res_found_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        load_out        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = unit_mod_word;
        mem_raddr       = addr_reg;
        unit_word       = mem_rdata;
        unit_ctl.op     = (req_reg == REQ_SET) ? UOP_SET : UOP_FLIP;
        unit_ctl.sel    = idx_reg[SEL_W-1:0];
        unit_ctl.value  = val_reg;
        unit_ctl.invert = ~val_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(DEPTH - 1)) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next        = s_req;
                    idx_next        = s_bit_index;
                    val_next        = s_value;
                    cnt_next        = cnt_eff;
                    res_bit_next    = 1'b0;
                    res_found_next  = 1'b0;
                    res_index_next  = '0;
                    res_status_next = 1'b0;
                    if (s_req == REQ_FIND) begin
                        addr_next = '0;
                        mem_raddr = '0;
                        last_next = AW'((cnt_eff - 1'b1) >> SEL_W);
                        state_next = (cnt_eff == '0) ? ST_DONE : ST_SCAN;
                    end else if (CNT_W'(s_bit_index) >= cnt_eff) begin
                        res_status_next = 1'b1;
                        state_next      = ST_DONE;
                    end else begin
                        addr_next  = AW'(s_bit_index >> SEL_W);
                        mem_raddr  = AW'(s_bit_index >> SEL_W);
                        state_next = ST_MODIFY;
                    end
                end
            end
            ST_MODIFY: begin
                mem_we       = (req_reg != REQ_GET);
                res_bit_next = (req_reg == REQ_GET) ? unit_res.bit_val : 1'b0;
                state_next   = ST_DONE;
            end
            ST_SCAN: begin
                // The read for the following word goes out while this one is tested.
                mem_raddr = addr_reg + 1'b1;
                if (unit_res.nonzero) begin
                    hit_word_next = mem_rdata;
                    lsb_next      = unit_res.lsb;
                    state_next    = ST_HIT;
                end else if (addr_reg == last_reg) begin
                    state_next = ST_DONE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_HIT: begin
                unit_word    = hit_word_reg;
                unit_ctl.op  = UOP_FLIP;
                unit_ctl.sel = lsb_reg;
                // The first match can lie past the count in the last word.
                if (CMP_W'(hit_pos) < CMP_W'(cnt_reg)) begin
                    mem_we         = 1'b1;
                    res_found_next = 1'b1;
                    res_index_next = IDX_W'(hit_pos);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            m_valid_reg   <= 1'b0;
            bit_count_reg <= BIT_COUNT_RESET;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                bit_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_reg       <= last_next;
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        cnt_reg        <= cnt_next;
        hit_word_reg   <= hit_word_next;
        lsb_reg        <= lsb_next;
        res_bit_reg    <= res_bit_next;
        res_found_reg  <= res_found_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        if (load_out) begin
            m_bit_reg    <= res_bit_reg;
            m_found_reg  <= res_found_reg;
            m_index_reg  <= res_index_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_bit_value   = m_bit_reg;
    assign m_found       = m_found_reg;
    assign m_found_index = m_index_reg;
    assign m_status      = m_status_reg;

endmodule

@@ hdl/bff_checker.sv @@
module bff_checker import bff_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_bit_value,
    input logic             m_found,
    input logic [IDX_W-1:0] m_found_index,
    input logic             m_status
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found_index) && $stable(m_found)
            && $stable(m_status) && $stable(m_bit_value))
        else $error("result beat changed while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_status && !m_bit_value)
        else $error("find result carries get or error fields");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_found && (m_found_index == '0) && !m_bit_value)
        else $error("error result carries data");

    a_no_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_found_index == '0))
        else $error("index reported without a find hit");

endmodule

bind bitmap_find_and_flip_store bff_checker u_bff_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_bit_value   (m_bit_value),
    .m_found       (m_found),
    .m_found_index (m_found_index),
    .m_status      (m_status)
);

@@ tb/bitmap_find_and_flip_store_tb.sv @@
module bitmap_find_and_flip_store_tb;
    import bff_pkg::*;

    typedef struct {
        req_t             kind;
        logic [IDX_W-1:0] index;
        logic             value;
    } request_t;

    typedef struct {
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             status;
    } outcome_t;

    typedef struct {
        request_t rq;
        outcome_t out;
    } pending_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_req_type = '0;
    logic [IDX_W-1:0] s_bit_index = '0;
    logic             s_value = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_bit_value;
    logic             m_found;
    logic [IDX_W-1:0] m_found_index;
    logic             m_status;

    // Predictor state: a private copy of the map and of the count register.
    logic [WORD_BITS-1:0] map_image [MAX_BITS_DEF / WORD_BITS];
    int unsigned          count_model = BIT_COUNT_RESET;

    request_t        request_queue [$];
    pending_result_t pending_results [$];
    request_t        on_bus;
    int              mismatches = 0;
    bit              steady = 1'b0;

    bitmap_find_and_flip_store dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_bit_index  (s_bit_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bit_value  (m_bit_value),
        .m_found      (m_found),
        .m_found_index(m_found_index),
        .m_status     (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned live_bits();
        return (count_model > MAX_BITS_DEF) ? MAX_BITS_DEF : count_model;
    endfunction

    // Applies one request to the map copy and returns the result it must produce.
    function automatic outcome_t serve_request(request_t rq);
        outcome_t             o;
        int unsigned          live;
        int unsigned          nwords;
        int unsigned          pos;
        int                   low;
        bit                   done;
        logic [WORD_BITS-1:0] norm;
        o = '{default: '0};
        live = live_bits();
        if (rq.kind == REQ_FIND) begin
            nwords = (live + 63) / 64;
            done = 1'b0;
            for (int w = 0; w < nwords && !done; w++) begin
                norm = rq.value ? map_image[w] : ~map_image[w];
                if (norm != '0) begin
                    done = 1'b1;
                    low = 0;
                    for (int b = WORD_BITS - 1; b >= 0; b--) begin
                        if (norm[b]) low = b;
                    end
                    pos = w * WORD_BITS + low;
                    // A match past the count in the last word ends the search empty-handed.
                    if (pos < live) begin
                        map_image[w][low] = ~map_image[w][low];
                        o.found = 1'b1;
                        o.found_index = pos[IDX_W-1:0];
                    end
                end
            end
        end else if (rq.index >= live) begin
            o.status = 1'b1;
        end else begin
            case (rq.kind)
                REQ_GET:  o.bit_value = map_image[rq.index[11:6]][rq.index[5:0]];
                REQ_SET:  map_image[rq.index[11:6]][rq.index[5:0]] = rq.value;
                default:  map_image[rq.index[11:6]][rq.index[5:0]] =
                              ~map_image[rq.index[11:6]][rq.index[5:0]];
            endcase
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back('{rq: on_bus, out: serve_request(on_bus)});
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
                    on_bus = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= on_bus.kind;
                    s_bit_index <= on_bus.index;
                    s_value <= on_bus.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        pending_result_t head;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: bv %0d found %0d idx %0d status %0d",
                                 m_bit_value, m_found, m_found_index, m_status);
                end else begin
                    head = pending_results.pop_front();
                    if (m_bit_value !== head.out.bit_value || m_found !== head.out.found ||
                        m_found_index !== head.out.found_index ||
                        m_status !== head.out.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch on %s idx %0d val %0d: expected bv %0d ",
                                      "found %0d idx %0d status %0d, got bv %0d found %0d ",
                                      "idx %0d status %0d"},
                                     head.rq.kind.name(), head.rq.index, head.rq.value,
                                     head.out.bit_value, head.out.found,
                                     head.out.found_index, head.out.status,
                                     m_bit_value, m_found, m_found_index, m_status);
                    end
                end
            end
            m_ready <= steady || $urandom_range(99) >= 11;
        end
    end

    task automatic push_request(req_t kind, int unsigned index, logic value);
        request_queue.push_back('{kind: kind, index: index[IDX_W-1:0], value: value});
    endtask

    task automatic drain();
        @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_bit_count(int unsigned count);
        drain();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count[CNT_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        count_model = count[CNT_W-1:0];
        @(negedge aclk);
    endtask

    // Mostly allocate/release/probe bursts aimed at the low end of the map, where
    // allocations pile up, plus some fully random requests.
    task automatic fill_random(int n);
        int          added;
        int          len;
        int unsigned live;
        int unsigned hi;
        int unsigned idx;
        added = 0;
        live = live_bits();
        hi = (live == 0) ? 0 : ((live < 256) ? live - 1 : 255);
        while (added < n) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    len = $urandom_range(12, 1);
                    repeat (len) push_request(REQ_FIND, $urandom_range(4095), 1'b0);
                end
                3: begin
                    len = $urandom_range(6, 1);
                    repeat (len) push_request(REQ_FIND, $urandom_range(4095), 1'b1);
                end
                4, 5, 6, 7: begin
                    len = $urandom_range(8, 1);
                    repeat (len) begin
                        idx = ($urandom_range(3) == 0 && live > 0) ?
                              $urandom_range(live - 1) : $urandom_range(hi);
                        push_request(req_t'($urandom_range(2)), idx, 1'($urandom_range(1)));
                    end
                end
                default: begin
                    len = 1;
                    idx = (live < 4096 && $urandom_range(1) == 0) ?
                          $urandom_range(4095, live) : $urandom_range(4095);
                    push_request(req_t'($urandom_range(3)), idx, 1'($urandom_range(1)));
                end
            endcase
            added += len;
        end
        drain();
    endtask

    initial begin
        for (int w = 0; w < MAX_BITS_DEF / WORD_BITS; w++) map_image[w] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_request(REQ_GET,  0,    1'b0);
        push_request(REQ_GET,  4095, 1'b1);
        push_request(REQ_SET,  4095, 1'b1);
        push_request(REQ_GET,  4095, 1'b0);
        push_request(REQ_FLIP, 0,    1'b0);
        push_request(REQ_GET,  0,    1'b0);
        push_request(REQ_FIND, 0,    1'b1);
        push_request(REQ_FIND, 0,    1'b1);
        // The map is empty again, so this search walks every word and finds nothing.
        push_request(REQ_FIND, 4095, 1'b1);
        push_request(REQ_FIND, 0,    1'b0);
        push_request(REQ_SET,  0,    1'b0);
        push_request(REQ_FLIP, 63,   1'b1);
        push_request(REQ_FLIP, 64,   1'b0);
        push_request(REQ_GET,  64,   1'b0);
        push_request(REQ_SET,  4000, 1'b1);
        push_request(REQ_SET,  120,  1'b1);

        write_bit_count(0);
        push_request(REQ_GET,  0,    1'b0);
        push_request(REQ_SET,  5,    1'b1);
        push_request(REQ_FLIP, 4095, 1'b0);
        push_request(REQ_FIND, 0,    1'b0);
        push_request(REQ_FIND, 0,    1'b1);

        // Bits at 120 and 4000 stay set but are hidden while the count is 100.
        write_bit_count(100);
        push_request(REQ_GET,  120,  1'b0);
        push_request(REQ_FIND, 0,    1'b1);
        push_request(REQ_FIND, 0,    1'b1);
        push_request(REQ_FIND, 0,    1'b1);
        push_request(REQ_GET,  100,  1'b0);

        write_bit_count(8191);
        push_request(REQ_GET,  120,  1'b0);
        push_request(REQ_GET,  4000, 1'b0);
        fill_random(70);

        write_bit_count(4096);
        steady = 1'b1;
        fill_random(150);
        steady = 1'b0;

        write_bit_count(130);
        fill_random(70);
        write_bit_count(65);
        fill_random(70);
        write_bit_count(1);
        fill_random(70);
        write_bit_count(64);
        fill_random(70);
        write_bit_count(0);
        fill_random(40);
        write_bit_count(5000);
        fill_random(70);
        write_bit_count(4095);
        fill_random(70);
        write_bit_count($urandom_range(300, 2));
        fill_random(70);
        write_bit_count($urandom_range(8191));
        fill_random(70);
        write_bit_count(200);
        fill_random(70);

        drain();
        repeat (80) @(posedge aclk);
        if (pending_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ bitmap_find_and_flip_store.f @@
hdl/bff_pkg.sv
hdl/bff_map_ram.sv
hdl/bff_word_unit.sv
hdl/bff_ctrl.sv
hdl/bitmap_find_and_flip_store.sv
hdl/bff_checker.sv
tb/bitmap_find_and_flip_store_tb.sv
